FILE: src/csb_pkg.sv
package csb_pkg;

   // Sizes of the blit geometry
   localparam int MAX_DIM     = 4096;
   localparam int DIM_WIDTH   = 13;
   localparam int POS_WIDTH   = 14;
   localparam int ADDR_WIDTH  = 24;
   localparam int PIXEL_WIDTH = 32;
   localparam int RGB_WIDTH   = 24;

   // Queue sizes between the parts
   localparam int CMD_DEPTH       = 8;
   localparam int CMD_PTR_WIDTH   = 3;
   localparam int CMD_COUNT_WIDTH = 4;
   localparam int RSP_DEPTH       = 4;
   localparam int RSP_PTR_WIDTH   = 2;
   localparam int RSP_COUNT_WIDTH = 3;

   // Register port
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 14;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_SCREEN_WIDTH  = 3'd0,
      CSR_SCREEN_HEIGHT = 3'd1,
      CSR_SPRITE_WIDTH  = 3'd2,
      CSR_SPRITE_HEIGHT = 3'd3,
      CSR_POS_X         = 3'd4,
      CSR_POS_Y         = 3'd5
   } csr_index_type;

   // Item kinds
   localparam logic KIND_START = 1'b0;
   localparam logic KIND_PIXEL = 1'b1;

   typedef struct packed {
      logic                   kind;
      logic [PIXEL_WIDTH-1:0] source_pixel;
      logic [PIXEL_WIDTH-1:0] dest_pixel;
   } req_type;

   typedef struct packed {
      logic [ADDR_WIDTH-1:0] dest_address;
      logic [ADDR_WIDTH-1:0] source_index;
      logic [RGB_WIDTH-1:0]  blended_pixel;
      logic                  last_pixel;
      logic                  no_blit;
   } rsp_type;

   typedef struct packed {
      logic [DIM_WIDTH-1:0]        screen_width;
      logic [DIM_WIDTH-1:0]        screen_height;
      logic [DIM_WIDTH-1:0]        sprite_width;
      logic [DIM_WIDTH-1:0]        sprite_height;
      logic signed [POS_WIDTH-1:0] pos_x;
      logic signed [POS_WIDTH-1:0] pos_y;
   } cfg_type;

   // One entry of the queue between front and back
   typedef struct packed {
      logic                   kind;
      logic                   empty_clip;
      logic [DIM_WIDTH-1:0]   visible_width;
      logic [DIM_WIDTH-1:0]   visible_height;
      logic [ADDR_WIDTH-1:0]  dest_row_base;
      logic [ADDR_WIDTH-1:0]  source_row_base;
      logic [PIXEL_WIDTH-1:0] source_pixel;
      logic [PIXEL_WIDTH-1:0] dest_pixel;
   } cmd_type;

   // Clamp a size register to the largest supported dimension
   function automatic logic [DIM_WIDTH-1:0] sat_dim(input logic [DIM_WIDTH-1:0] v);
      logic [DIM_WIDTH-1:0] r;
      r = (v > DIM_WIDTH'(MAX_DIM)) ? DIM_WIDTH'(MAX_DIM) : v;
      return r;
   endfunction

endpackage

FILE: src/clipped_alpha_sprite_blit_core.sv
// Alpha-blended sprite blit with screen clipping. Both sides behave as queues:
// one item is taken per clock while full is low, and one result can be taken per
// clock while empty is low. A start item costs no result; it clips the sprite in
// two front stages (clip, then the row-base multiplies) and loads the walk state
// when it reaches the back. Each pixel item gives one result, which passes through
// two front stages, the command queue, the walk and product stage, then the
// divide-by-255 stage into a four-entry result queue.
// Throughput is one item per clock for as long as results are taken; full rises
// once eight items sit between the input and the back end. Registers are sampled
// at a start's transfer; the row steps use the width registers as they stand.
module clipped_alpha_sprite_blit_core
   import csb_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   output logic                       full,
   input  req_type                    req_data,
   output logic                       empty,
   input  logic                       pop,
   output rsp_type                    rsp_data,
   input  logic                       csr_write,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data
);

   cfg_type                    cfg;
   logic                       cmd_push;
   logic                       cmd_pop;
   cmd_type                    cmd_in_data;
   cmd_type                    cmd_head;
   logic [CMD_COUNT_WIDTH-1:0] cmd_count;

   csb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   csb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .cmd_count (cmd_count),
      .cmd_push  (cmd_push),
      .cmd_data  (cmd_in_data)
   );

   csb_cmd_queue u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in_data),
      .pop       (cmd_pop),
      .head      (cmd_head),
      .count     (cmd_count)
   );

   csb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .head      (cmd_head),
      .cmd_count (cmd_count),
      .cmd_pop   (cmd_pop),
      .pop       (pop),
      .empty     (empty),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: src/csb_csr.sv
module csb_csr
   import csb_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data,
   output cfg_type                    cfg
);

   cfg_type cfg_ff, cfg_in;

   // Decode the register write
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_SCREEN_WIDTH:  cfg_in.screen_width  = csr_data[DIM_WIDTH-1:0];
            CSR_SCREEN_HEIGHT: cfg_in.screen_height = csr_data[DIM_WIDTH-1:0];
            CSR_SPRITE_WIDTH:  cfg_in.sprite_width  = csr_data[DIM_WIDTH-1:0];
            CSR_SPRITE_HEIGHT: cfg_in.sprite_height = csr_data[DIM_WIDTH-1:0];
            CSR_POS_X:         cfg_in.pos_x         = csr_data[POS_WIDTH-1:0];
            CSR_POS_Y:         cfg_in.pos_y         = csr_data[POS_WIDTH-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.screen_width  <= DIM_WIDTH'(640);
         cfg_ff.screen_height <= DIM_WIDTH'(480);
         cfg_ff.sprite_width  <= DIM_WIDTH'(1);
         cfg_ff.sprite_height <= DIM_WIDTH'(1);
         cfg_ff.pos_x         <= '0;
         cfg_ff.pos_y         <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: src/csb_front.sv
module csb_front
   import csb_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  cfg_type                    cfg,
   input  logic                       push,
   output logic                       full,
   input  req_type                    req_data,
   input  logic [CMD_COUNT_WIDTH-1:0] cmd_count,
   output logic                       cmd_push,
   output cmd_type                    cmd_data
);

   typedef struct packed {
      logic                   kind;
      logic [PIXEL_WIDTH-1:0] source_pixel;
      logic [PIXEL_WIDTH-1:0] dest_pixel;
      logic                   empty_clip;
      logic [DIM_WIDTH-1:0]   visible_width;
      logic [DIM_WIDTH-1:0]   visible_height;
      logic [11:0]            dest_row_off;
      logic [DIM_WIDTH-1:0]   dest_pitch;
      logic [11:0]            dest_col;
      logic [11:0]            source_row_off;
      logic [DIM_WIDTH-1:0]   source_pitch;
      logic [11:0]            source_col;
   } clip_stage_type;

   typedef struct packed {
      logic                   kind;
      logic [PIXEL_WIDTH-1:0] source_pixel;
      logic [PIXEL_WIDTH-1:0] dest_pixel;
      logic                   empty_clip;
      logic [DIM_WIDTH-1:0]   visible_width;
      logic [DIM_WIDTH-1:0]   visible_height;
      logic [24:0]            dest_product;
      logic [24:0]            source_product;
      logic [11:0]            dest_col;
      logic [11:0]            source_col;
   } mul_stage_type;

   logic                 accept;
   logic                 clip_valid_ff, clip_valid_in;
   logic                 mul_valid_ff, mul_valid_in;
   clip_stage_type       clip_ff, clip_in;
   mul_stage_type        mul_ff, mul_in;
   logic [CMD_COUNT_WIDTH:0] occupancy;

   logic [DIM_WIDTH-1:0] sw, sh, w, h;
   logic signed [15:0]   x, y, sw_s, sh_s, w_s, h_s, xw, yh;
   logic signed [15:0]   left, right, bottom, top;
   logic signed [15:0]   width_diff, height_diff, dest_row_diff, source_row_diff, source_col_diff;

   // Credit: every item in the front or the queue owns a queue slot
   assign occupancy = (CMD_COUNT_WIDTH+1)'(cmd_count) + (CMD_COUNT_WIDTH+1)'(clip_valid_ff)
                      + (CMD_COUNT_WIDTH+1)'(mul_valid_ff);
   assign full   = occupancy >= (CMD_COUNT_WIDTH+1)'(CMD_DEPTH);
   assign accept = push && !full;

   // Clip the sprite rectangle against the screen
   always_comb begin
      sw   = sat_dim(cfg.screen_width);
      sh   = sat_dim(cfg.screen_height);
      w    = sat_dim(cfg.sprite_width);
      h    = sat_dim(cfg.sprite_height);
      x    = {{2{cfg.pos_x[POS_WIDTH-1]}}, cfg.pos_x};
      y    = {{2{cfg.pos_y[POS_WIDTH-1]}}, cfg.pos_y};
      sw_s = {3'b000, sw};
      sh_s = {3'b000, sh};
      w_s  = {3'b000, w};
      h_s  = {3'b000, h};
      xw   = x + w_s;
      yh   = y + h_s;
      left   = (x > 16'sd0) ? x : 16'sd0;
      right  = (xw < sw_s) ? xw : sw_s;
      bottom = (y > 16'sd0) ? y : 16'sd0;
      top    = (yh < sh_s) ? yh : sh_s;
      width_diff      = right - left;
      height_diff     = top - bottom;
      dest_row_diff   = sh_s - top;
      source_row_diff = top - 16'sd1 - y;
      source_col_diff = left - x;

      clip_in.kind           = req_data.kind;
      clip_in.source_pixel   = req_data.source_pixel;
      clip_in.dest_pixel     = req_data.dest_pixel;
      clip_in.empty_clip     = (right <= left) || (top <= bottom);
      clip_in.visible_width  = width_diff[DIM_WIDTH-1:0];
      clip_in.visible_height = height_diff[DIM_WIDTH-1:0];
      clip_in.dest_row_off   = dest_row_diff[11:0];
      clip_in.dest_pitch     = sw;
      clip_in.dest_col       = left[11:0];
      clip_in.source_row_off = source_row_diff[11:0];
      clip_in.source_pitch   = w;
      clip_in.source_col     = source_col_diff[11:0];
   end

   // Row base products
   always_comb begin
      mul_in.kind           = clip_ff.kind;
      mul_in.source_pixel   = clip_ff.source_pixel;
      mul_in.dest_pixel     = clip_ff.dest_pixel;
      mul_in.empty_clip     = clip_ff.empty_clip;
      mul_in.visible_width  = clip_ff.visible_width;
      mul_in.visible_height = clip_ff.visible_height;
      mul_in.dest_product   = 25'(clip_ff.dest_row_off) * 25'(clip_ff.dest_pitch);
      mul_in.source_product = 25'(clip_ff.source_row_off) * 25'(clip_ff.source_pitch);
      mul_in.dest_col       = clip_ff.dest_col;
      mul_in.source_col     = clip_ff.source_col;
   end

   assign clip_valid_in = accept;
   assign mul_valid_in  = clip_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_valid_ff <= 1'b0;
         mul_valid_ff  <= 1'b0;
      end else begin
         clip_valid_ff <= clip_valid_in;
         mul_valid_ff  <= mul_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      clip_ff <= clip_in;
      mul_ff  <= mul_in;
   end

   // Final offsets and transfer into the queue
   always_comb begin
      cmd_data.kind            = mul_ff.kind;
      cmd_data.empty_clip      = mul_ff.empty_clip;
      cmd_data.visible_width   = mul_ff.visible_width;
      cmd_data.visible_height  = mul_ff.visible_height;
      cmd_data.dest_row_base   = mul_ff.dest_product[ADDR_WIDTH-1:0]
                                 + ADDR_WIDTH'(mul_ff.dest_col);
      cmd_data.source_row_base = mul_ff.source_product[ADDR_WIDTH-1:0]
                                 + ADDR_WIDTH'(mul_ff.source_col);
      cmd_data.source_pixel    = mul_ff.source_pixel;
      cmd_data.dest_pixel      = mul_ff.dest_pixel;
   end

   assign cmd_push = mul_valid_ff;

endmodule

FILE: src/csb_cmd_queue.sv
module csb_cmd_queue
   import csb_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  cmd_type                    push_data,
   input  logic                       pop,
   output cmd_type                    head,
   output logic [CMD_COUNT_WIDTH-1:0] count
);

   cmd_type                    mem_ff [CMD_DEPTH];
   logic [CMD_PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMD_COUNT_WIDTH-1:0] count_ff, count_in;

   // Pointer and fill bookkeeping; the front never pushes without a free slot
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + CMD_PTR_WIDTH'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + CMD_PTR_WIDTH'(1) : rd_ptr_ff;
      count_in  = count_ff + CMD_COUNT_WIDTH'(push) - CMD_COUNT_WIDTH'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head  = mem_ff[rd_ptr_ff];
   assign count = count_ff;

endmodule

FILE: src/csb_back.sv
module csb_back
   import csb_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  cfg_type                    cfg,
   input  cmd_type                    head,
   input  logic [CMD_COUNT_WIDTH-1:0] cmd_count,
   output logic                       cmd_pop,
   input  logic                       pop,
   output logic                       empty,
   output rsp_type                    rsp_data
);

   typedef struct packed {
      logic [ADDR_WIDTH-1:0] dest_address;
      logic [ADDR_WIDTH-1:0] source_index;
      logic                  last_pixel;
      logic                  no_blit;
      logic [2:0][15:0]      source_product;
      logic [2:0][15:0]      dest_product;
   } blend_stage_type;

   // floor(sum / 255) for sums below 65280 (255 * 256)
   function automatic logic [7:0] div255(input logic [15:0] a, input logic [15:0] b);
      logic [15:0] sum;
      logic [16:0] t;
      sum = a + b;
      t   = 17'(sum) + 17'd1 + 17'(sum[15:8]);
      return t[15:8];
   endfunction

   // Blit walk state
   logic                  active_ff, active_in;
   logic [11:0]           column_ff, column_in;
   logic [11:0]           row_ff, row_in;
   logic [DIM_WIDTH-1:0]  vis_w_ff, vis_w_in;
   logic [DIM_WIDTH-1:0]  vis_h_ff, vis_h_in;
   logic [ADDR_WIDTH-1:0] dest_base_ff, dest_base_in;
   logic [ADDR_WIDTH-1:0] source_base_ff, source_base_in;

   logic                  blend_valid_ff, blend_valid_in;
   blend_stage_type       blend_ff, blend_in;

   // Result queue
   rsp_type                    rsp_mem_ff [RSP_DEPTH];
   logic [RSP_PTR_WIDTH-1:0]   rsp_wr_ff, rsp_wr_in;
   logic [RSP_PTR_WIDTH-1:0]   rsp_rd_ff, rsp_rd_in;
   logic [RSP_COUNT_WIDTH-1:0] rsp_count_ff, rsp_count_in;
   logic [RSP_COUNT_WIDTH-1:0] rsp_occupancy;
   rsp_type                    rsp_push_data;
   logic                       rsp_pop_ok;

   logic       column_end, row_end, pixel_pop, start_pop;
   logic [7:0] alpha, alpha_inv;

   // Take a command when the result side has a slot reserved for it
   assign rsp_occupancy = rsp_count_ff + RSP_COUNT_WIDTH'(blend_valid_ff);
   assign cmd_pop   = (cmd_count != '0) && (rsp_occupancy < RSP_COUNT_WIDTH'(RSP_DEPTH));
   assign pixel_pop = cmd_pop && (head.kind == KIND_PIXEL);
   assign start_pop = cmd_pop && (head.kind == KIND_START);

   assign column_end = ({1'b0, column_ff} + DIM_WIDTH'(1)) >= vis_w_ff;
   assign row_end    = ({1'b0, row_ff} + DIM_WIDTH'(1)) >= vis_h_ff;

   // Walk the visible rectangle
   always_comb begin
      active_in      = active_ff;
      column_in      = column_ff;
      row_in         = row_ff;
      vis_w_in       = vis_w_ff;
      vis_h_in       = vis_h_ff;
      dest_base_in   = dest_base_ff;
      source_base_in = source_base_ff;
      if (start_pop) begin
         active_in = !head.empty_clip;
         column_in = '0;
         row_in    = '0;
         vis_w_in  = head.visible_width;
         vis_h_in  = head.visible_height;
         if (!head.empty_clip) begin
            dest_base_in   = head.dest_row_base;
            source_base_in = head.source_row_base;
         end
      end else if (pixel_pop && active_ff) begin
         if (column_end) begin
            column_in = '0;
            if (row_end) begin
               row_in    = '0;
               active_in = 1'b0;
            end else begin
               row_in         = row_ff + 12'd1;
               dest_base_in   = dest_base_ff + ADDR_WIDTH'(sat_dim(cfg.screen_width));
               source_base_in = source_base_ff - ADDR_WIDTH'(sat_dim(cfg.sprite_width));
            end
         end else begin
            column_in = column_ff + 12'd1;
         end
      end
   end

   // Addresses and blend products for the popped pixel
   always_comb begin
      alpha     = head.source_pixel[31:24];
      alpha_inv = 8'd255 - alpha;
      blend_in.no_blit = !active_ff;
      if (active_ff) begin
         blend_in.dest_address = dest_base_ff + ADDR_WIDTH'(column_ff);
         blend_in.source_index = source_base_ff + ADDR_WIDTH'(column_ff);
         blend_in.last_pixel   = column_end && row_end;
      end else begin
         blend_in.dest_address = '0;
         blend_in.source_index = '0;
         blend_in.last_pixel   = 1'b0;
      end
      for (int c = 0; c < 3; c++) begin
         if (active_ff) begin
            blend_in.source_product[c] = 16'(alpha) * 16'(head.source_pixel[8*c +: 8]);
            blend_in.dest_product[c]   = 16'(alpha_inv) * 16'(head.dest_pixel[8*c +: 8]);
         end else begin
            blend_in.source_product[c] = '0;
            blend_in.dest_product[c]   = '0;
         end
      end
   end

   assign blend_valid_in = pixel_pop;

   // Sum and scale each channel into the result
   always_comb begin
      rsp_push_data.dest_address  = blend_ff.dest_address;
      rsp_push_data.source_index  = blend_ff.source_index;
      rsp_push_data.last_pixel    = blend_ff.last_pixel;
      rsp_push_data.no_blit       = blend_ff.no_blit;
      rsp_push_data.blended_pixel = {
         div255(blend_ff.source_product[2], blend_ff.dest_product[2]),
         div255(blend_ff.source_product[1], blend_ff.dest_product[1]),
         div255(blend_ff.source_product[0], blend_ff.dest_product[0])};
   end

   // Result queue bookkeeping
   assign rsp_pop_ok = pop && (rsp_count_ff != '0);
   always_comb begin
      rsp_wr_in    = blend_valid_ff ? rsp_wr_ff + RSP_PTR_WIDTH'(1) : rsp_wr_ff;
      rsp_rd_in    = rsp_pop_ok ? rsp_rd_ff + RSP_PTR_WIDTH'(1) : rsp_rd_ff;
      rsp_count_in = rsp_count_ff + RSP_COUNT_WIDTH'(blend_valid_ff)
                     - RSP_COUNT_WIDTH'(rsp_pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff      <= 1'b0;
         column_ff      <= '0;
         row_ff         <= '0;
         vis_w_ff       <= '0;
         vis_h_ff       <= '0;
         dest_base_ff   <= '0;
         source_base_ff <= '0;
         blend_valid_ff <= 1'b0;
         rsp_wr_ff      <= '0;
         rsp_rd_ff      <= '0;
         rsp_count_ff   <= '0;
      end else begin
         active_ff      <= active_in;
         column_ff      <= column_in;
         row_ff         <= row_in;
         vis_w_ff       <= vis_w_in;
         vis_h_ff       <= vis_h_in;
         dest_base_ff   <= dest_base_in;
         source_base_ff <= source_base_in;
         blend_valid_ff <= blend_valid_in;
         rsp_wr_ff      <= rsp_wr_in;
         rsp_rd_ff      <= rsp_rd_in;
         rsp_count_ff   <= rsp_count_in;
      end
   end

   always_ff @(posedge clock) begin
      blend_ff <= blend_in;
      if (blend_valid_ff) begin
         rsp_mem_ff[rsp_wr_ff] <= rsp_push_data;
      end
   end

   assign empty    = (rsp_count_ff == '0);
   assign rsp_data = rsp_mem_ff[rsp_rd_ff];

endmodule

FILE: src/csb_checker.sv
module csb_checker
   import csb_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    push,
   input logic    full,
   input req_type req_data,
   input logic    pop,
   input logic    empty,
   input rsp_type rsp_data
);

   logic [5:0] pending_ff, pending_in;
   logic       pixel_transfer, rsp_transfer;

   // Pixel items transferred in but not yet answered
   assign pixel_transfer = push && !full && (req_data.kind == KIND_PIXEL);
   assign rsp_transfer   = pop && !empty;
   assign pending_in     = pending_ff + 6'(pixel_transfer) - 6'(rsp_transfer);

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // Nothing to take straight after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("result waiting after reset");

   // Every result answers a pixel item
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_transfer |-> (pending_ff != 6'd0))
      else $error("result without a pixel item");

   // An orphan pixel result carries nothing but its flag
   a_no_blit_clean: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.no_blit) |-> (rsp_data.dest_address == '0
         && rsp_data.source_index == '0 && rsp_data.blended_pixel == '0
         && !rsp_data.last_pixel))
      else $error("no_blit result with payload");

   // A waiting result stays put until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_data)))
      else $error("waiting result changed");

endmodule

bind clipped_alpha_sprite_blit_core csb_checker u_csb_checker (.*);
